// ----- sv/hdbsf_pkg.sv -----
// ----------------------------------------------------------------------------
// Half-duplex byte stuffing framer: shared package
// Operation and result codes, line constants, phase encodings and the
// result bundle that travels from the framing core to the output serialiser.
// ----------------------------------------------------------------------------
package hdbsf_pkg;

    // Line-level special bytes.
    localparam logic [7:0] BYTE_DELIM = 8'h7E;
    localparam logic [7:0] BYTE_START = 8'h81;
    localparam logic [7:0] BYTE_STUFF = 8'hE7;

    // Largest number of results one input item can cause.
    localparam int BurstDepth = 4;
    localparam int CntW       = $clog2(BurstDepth + 1);
    localparam int IdxW       = $clog2(BurstDepth);

    // Input operation codes.
    typedef enum logic [1:0] {
        OP_LINE_RX  = 2'd0,
        OP_PAYLOAD  = 2'd1,
        OP_START_TX = 2'd2,
        OP_START_RX = 2'd3
    } t_op;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_LINE   = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_START  = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    // Transmit framing phase.
    typedef enum logic [1:0] {
        TXP_IDLE = 2'd0,
        TXP_OPEN = 2'd1
    } t_tx_phase;

    // Receive deframing phase.
    typedef enum logic [1:0] {
        RXP_HUNT  = 2'd0,
        RXP_DELIM = 2'd1,
        RXP_FRAME = 2'd2,
        RXP_ESC   = 2'd3
    } t_rx_phase;

    // One result item.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       run_last;
        logic       tx_done;
    } t_result;

    // All results of one input item, slot 0 first.
    typedef struct packed {
        t_result [BurstDepth-1:0] slot;
        logic [CntW-1:0]          count;
    } t_burst;

endpackage

// ----- sv/hdbsf_core.sv -----
// ----------------------------------------------------------------------------
// Half-duplex byte stuffing framer: framing core
// Holds the direction flag and the transmit and receive phases, and turns
// one registered input item into its bundle of results in a single pass.
// ----------------------------------------------------------------------------
module hdbsf_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  hdbsf_pkg::t_op      i_op,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_payload,
    output hdbsf_pkg::t_burst   o_burst
);
    import hdbsf_pkg::*;

    t_tx_phase r_tx_phase, n_tx_phase;
    t_rx_phase r_rx_phase, n_rx_phase;
    logic      r_turn, n_turn;

    t_burst    burst;
    logic      tx_end;
    logic      pre;
    logic      stuff;

    assign pre   = (r_tx_phase == TXP_IDLE);
    assign stuff = (i_data_byte == BYTE_DELIM);

    // Next state and the result bundle for the item in the input register.
    always_comb begin
        n_tx_phase  = r_tx_phase;
        n_rx_phase  = r_rx_phase;
        n_turn      = r_turn;
        burst       = '0;
        tx_end      = 1'b0;

        unique case (i_op)
            OP_LINE_RX: begin
                if (!r_turn) begin
                    unique case (r_rx_phase)
                        RXP_HUNT: begin
                            if (i_data_byte == BYTE_DELIM) begin
                                n_rx_phase = RXP_DELIM;
                            end
                        end
                        RXP_DELIM: begin
                            if (i_data_byte == BYTE_START) begin
                                burst.slot[0].kind = KIND_START;
                                burst.count        = CntW'(1);
                                n_rx_phase         = RXP_FRAME;
                            end else begin
                                n_rx_phase = RXP_HUNT;
                            end
                        end
                        RXP_FRAME: begin
                            if (i_data_byte == BYTE_DELIM) begin
                                n_rx_phase = RXP_ESC;
                            end else begin
                                burst.slot[0].kind = KIND_DATA;
                                burst.slot[0].data = i_data_byte;
                                burst.count        = CntW'(1);
                            end
                        end
                        RXP_ESC: begin
                            if (i_data_byte == BYTE_START) begin
                                // Resync inside a frame.
                                burst.slot[0].kind = KIND_START;
                                burst.count        = CntW'(1);
                                n_rx_phase         = RXP_FRAME;
                            end else if (i_data_byte == BYTE_STUFF) begin
                                burst.slot[0].kind = KIND_DATA;
                                burst.slot[0].data = BYTE_DELIM;
                                burst.count        = CntW'(1);
                                n_rx_phase         = RXP_FRAME;
                            end else begin
                                n_rx_phase = RXP_HUNT;
                            end
                        end
                        default: begin
                            n_rx_phase = RXP_HUNT;
                        end
                    endcase
                end
            end
            OP_PAYLOAD: begin
                if (r_turn) begin
                    // Delimiter pair first when no frame is open, then the
                    // byte itself and a stuffing byte after a delimiter value.
                    burst.slot[0].kind = KIND_LINE;
                    burst.slot[1].kind = KIND_LINE;
                    burst.slot[2].kind = KIND_LINE;
                    burst.slot[3].kind = KIND_LINE;
                    burst.slot[0].data = pre ? BYTE_DELIM : i_data_byte;
                    burst.slot[1].data = pre ? BYTE_START : BYTE_STUFF;
                    burst.slot[2].data = i_data_byte;
                    burst.slot[3].data = BYTE_STUFF;
                    burst.count        = CntW'(1) + (pre ? CntW'(2) : CntW'(0))
                                         + (stuff ? CntW'(1) : CntW'(0));
                    n_tx_phase         = TXP_OPEN;
                    if (i_last_payload) begin
                        tx_end     = 1'b1;
                        n_tx_phase = TXP_IDLE;
                        n_turn     = 1'b0;
                    end
                end else begin
                    burst.slot[0].kind = KIND_REJECT;
                    burst.count        = CntW'(1);
                end
            end
            OP_START_TX: begin
                n_turn = 1'b1;
            end
            OP_START_RX: begin
                n_turn = 1'b0;
            end
            default: begin
                n_turn = r_turn;
            end
        endcase

        // Flag the final result of the item.
        for (int i = 0; i < BurstDepth; i++) begin
            if (CntW'(i) + CntW'(1) == burst.count) begin
                burst.slot[i].run_last = 1'b1;
                burst.slot[i].tx_done  = tx_end;
            end
        end
    end

    assign o_burst = burst;

    // Phase and direction registers, updated as an item leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_phase <= TXP_IDLE;
            r_rx_phase <= RXP_HUNT;
            r_turn     <= 1'b0;
        end else if (i_advance) begin
            r_tx_phase <= n_tx_phase;
            r_rx_phase <= n_rx_phase;
            r_turn     <= n_turn;
        end
    end

endmodule

// ----- sv/hdbsf_serialiser.sv -----
// ----------------------------------------------------------------------------
// Half-duplex byte stuffing framer: output serialiser
// Registers the result bundle of one item and hands its results out one
// per cycle while the consumer is ready, on the valid/ready output channel.
// ----------------------------------------------------------------------------
module hdbsf_serialiser (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  hdbsf_pkg::t_burst        i_burst,
    output logic                     o_free,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output hdbsf_pkg::t_result       o_result
);
    import hdbsf_pkg::*;

    t_burst             r_burst;
    logic [CntW-1:0]    r_count;
    logic [IdxW-1:0]    r_idx;
    logic               fire;
    logic               at_last;

    assign o_out_valid = (r_count != '0);
    assign fire        = o_out_valid && i_out_ready;
    assign at_last     = ({1'b0, r_idx} + CntW'(1) == r_count);
    assign o_free      = !o_out_valid || (fire && at_last);
    assign o_result    = r_burst.slot[r_idx];

    // Bundle payload; no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

    // Fill count and read position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_count <= i_burst.count;
            r_idx   <= '0;
        end else if (fire) begin
            if (at_last) begin
                r_count <= '0;
                r_idx   <= '0;
            end else begin
                r_idx <= r_idx + IdxW'(1);
            end
        end
    end

endmodule

// ----- sv/half_duplex_byte_stuffing_framer.sv -----
// ----------------------------------------------------------------------------
// An accepted item is held in the input register; its result bundle is loaded
// into the output serialiser as the item leaves, and is shown from there.
// Throughput: one result per cycle on the output while the consumer is ready; an
// item causes zero to four results, and a zero-result item skips the serialiser.
// Reset (synchronous, active low) empties both registers, clears the direction
// flag to receive and sets both framing phases to idle.
// ----------------------------------------------------------------------------
// Half-duplex byte stuffing framer
// Input register, framing core and output serialiser for a half-duplex link
// that stuffs payload bytes on transmit and unstuffs line bytes on receive.
// ----------------------------------------------------------------------------
module half_duplex_byte_stuffing_framer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_payload,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_tx_done
);
    import hdbsf_pkg::*;

    logic       r_in_valid;
    t_op        r_op;
    logic [7:0] r_data_byte;
    logic       r_last_payload;

    t_burst     burst;
    t_result    result;
    logic       ser_free;
    logic       advance;
    logic       load;

    // An item leaves the input register when it yields no result or when the
    // serialiser is empty or hands out its final result in this cycle.
    assign advance    = r_in_valid && ((burst.count == '0) || ser_free);
    assign load       = advance && (burst.count != '0);
    assign o_in_ready = !r_in_valid || advance;

    // Input register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op           <= t_op'(i_op);
            r_data_byte    <= i_data_byte;
            r_last_payload <= i_last_payload;
        end
    end

    hdbsf_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_op           (r_op),
        .i_data_byte    (r_data_byte),
        .i_last_payload (r_last_payload),
        .o_burst        (burst)
    );

    hdbsf_serialiser u_serialiser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_burst     (burst),
        .o_free      (ser_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_out_kind = result.kind;
    assign o_out_byte = result.data;
    assign o_run_last = result.run_last;
    assign o_tx_done  = result.tx_done;

    // A bundle is only loaded when the serialiser has room for it.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> ser_free)
        else $error("result bundle loaded over unfinished results");

    // A bundle never holds more results than one item can cause.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> (burst.count <= CntW'(BurstDepth)))
        else $error("result count out of range");

    // The end of a transmitted frame is always the last result of its item.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_tx_done) |-> o_run_last)
        else $error("frame end flagged on a result that is not the last");

    // A result held back by the consumer is still offered next cycle.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("pending result withdrawn");

endmodule
